// ----- rtl/tte_pkg.sv -----
// Package: types, codes and sizing for the transposition table engine.
`default_nettype none

package tte_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// operation codes
	localparam logic [2:0] FUNC_PROBE    = 3'd0;
	localparam logic [2:0] FUNC_MOVE     = 3'd1;
	localparam logic [2:0] FUNC_STORE    = 3'd2;
	localparam logic [2:0] FUNC_PV_MOVE  = 3'd3;
	localparam logic [2:0] FUNC_PV_STORE = 3'd4;
	localparam logic [2:0] FUNC_CLEAR    = 3'd5;

	// bound flags
	localparam logic [1:0] FLAG_EMPTY = 2'd0;
	localparam logic [1:0] FLAG_EXACT = 2'd1;
	localparam logic [1:0] FLAG_UPPER = 2'd2;
	localparam logic [1:0] FLAG_LOWER = 2'd3;

	// result status
	localparam logic [1:0] STAT_MISS  = 2'd0;
	localparam logic [1:0] STAT_EXACT = 2'd1;
	localparam logic [1:0] STAT_ALPHA = 2'd2;
	localparam logic [1:0] STAT_BETA  = 2'd3;
	localparam logic [1:0] STAT_HIT   = 2'd1;

	typedef struct packed {
		logic [2:0]         func;
		logic [63:0]        key;
		logic [63:0]        move_in;
		logic signed [23:0] score_in;
		logic signed [23:0] window_low;
		logic signed [23:0] window_high;
		logic [6:0]         search_depth;
		logic [1:0]         bound_kind;
	} tte_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [23:0] score_out;
		logic [63:0]        move_out;
	} tte_rsp_t;

	typedef struct packed {
		logic [63:0]        key;
		logic [63:0]        move;
		logic [6:0]         depth;
		logic [1:0]         flag;
		logic signed [23:0] score;
	} tte_entry_t;

	localparam int ENTRY_W = $bits(tte_entry_t);

	// controller -> datapath
	typedef struct packed {
		logic             capture;
		logic             commit;
		logic             sweep;
		logic [IDX_W-1:0] sweep_idx;
	} tte_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;
	} tte_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tte_req_if.sv -----
// Request channel interface: valid/ready handshake with the operation payload.
`default_nettype none

interface tte_req_if;
	import tte_pkg::*;

	logic     valid;
	logic     ready;
	tte_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tte_rsp_if.sv -----
// Result channel interface: valid/ready handshake with the result payload.
`default_nettype none

interface tte_rsp_if;
	import tte_pkg::*;

	logic     valid;
	logic     ready;
	tte_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tte_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/tte_datapath.sv -----
// Datapath: both table memories, request register, hit/bound logic and result register.
`default_nettype none

module tte_datapath (
	input  wire logic               clk,
	input  wire tte_pkg::tte_req_t  req_data,
	input  wire tte_pkg::tte_cmd_t  cmd,
	output tte_pkg::tte_stat_t      stat,
	output tte_pkg::tte_rsp_t       rsp_data
);
	import tte_pkg::*;

	tte_req_t         req_q;
	tte_rsp_t         rsp_q;
	tte_entry_t       main_rd;
	tte_entry_t       pv_rd;
	tte_entry_t       wr_entry;
	tte_rsp_t         res;
	logic             main_we;
	logic             pv_we;
	logic [IDX_W-1:0] waddr;
	logic             main_key_eq;
	logic             pv_key_eq;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_data;
		end
		if (cmd.commit) begin
			rsp_q <= res;
		end
	end

	assign main_key_eq = (main_rd.key == req_q.key);
	assign pv_key_eq   = (pv_rd.key == req_q.key);

	always_comb begin
		res     = '0;
		main_we = 1'b0;
		pv_we   = 1'b0;
		case (req_q.func)
			FUNC_PROBE: begin
				if (main_key_eq && main_rd.flag != FLAG_EMPTY
						&& main_rd.depth >= req_q.search_depth) begin
					if (main_rd.flag == FLAG_EXACT) begin
						res.status    = STAT_EXACT;
						res.score_out = main_rd.score;
						res.move_out  = main_rd.move;
					end else if (main_rd.flag == FLAG_UPPER
							&& $signed(main_rd.score) <= $signed(req_q.window_low)) begin
						res.status    = STAT_ALPHA;
						res.score_out = req_q.window_low;
					end else if (main_rd.flag == FLAG_LOWER
							&& $signed(main_rd.score) >= $signed(req_q.window_high)) begin
						res.status    = STAT_BETA;
						res.score_out = req_q.window_high;
					end
				end
			end
			FUNC_MOVE: begin
				if (main_key_eq && main_rd.flag != FLAG_EMPTY) begin
					res.status   = STAT_HIT;
					res.move_out = main_rd.move;
				end
			end
			FUNC_PV_MOVE: begin
				if (pv_key_eq && pv_rd.flag == FLAG_EXACT) begin
					res.status   = STAT_HIT;
					res.move_out = pv_rd.move;
				end
			end
			// same key with a deeper entry is kept
			FUNC_STORE: begin
				main_we = !(main_key_eq && req_q.search_depth < main_rd.depth);
			end
			FUNC_PV_STORE: begin
				pv_we = !(pv_key_eq && req_q.search_depth < pv_rd.depth);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (cmd.sweep) begin
			wr_entry = '0;
			waddr    = cmd.sweep_idx;
		end else begin
			wr_entry.key   = req_q.key;
			wr_entry.move  = req_q.move_in;
			wr_entry.depth = req_q.search_depth;
			wr_entry.flag  = req_q.bound_kind;
			wr_entry.score = req_q.score_in;
			waddr          = req_q.key[IDX_W-1:0];
		end
	end

	tte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_main_ram (
		.clk   (clk),
		.we    (cmd.sweep || (cmd.commit && main_we)),
		.waddr (waddr),
		.wdata (wr_entry),
		.re    (cmd.capture),
		.raddr (req_data.key[IDX_W-1:0]),
		.rdata (main_rd)
	);

	tte_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_pv_ram (
		.clk   (clk),
		.we    (cmd.sweep || (cmd.commit && pv_we)),
		.waddr (waddr),
		.wdata (wr_entry),
		.re    (cmd.capture),
		.raddr (req_data.key[IDX_W-1:0]),
		.rdata (pv_rd)
	);

	assign stat.is_clear = (req_q.func == FUNC_CLEAR);
	assign rsp_data      = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/tte_ctrl.sv -----
// Controller: sweep/idle/execute sequencing, handshakes and result valid.
`default_nettype none

module tte_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	input  wire tte_pkg::tte_stat_t stat,
	output tte_pkg::tte_cmd_t       cmd
);
	import tte_pkg::*;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic             can_commit;

	// result register is free or being emptied this cycle
	assign can_commit = !out_valid_q || rsp_ready;

	always_comb begin
		cmd.capture   = (state_q == ST_IDLE) && req_valid;
		cmd.commit    = (state_q == ST_EXEC) && can_commit;
		cmd.sweep     = (state_q == ST_SWEEP);
		cmd.sweep_idx = idx_q;
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (can_commit) begin
						idx_q   <= '0;
						state_q <= stat.is_clear ? ST_SWEEP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/transposition_table_engine.sv -----
// Top level: transposition table engine, controller plus datapath.
// An accepted request reads both tables, then is checked and written back as its result
// is registered; no new request is taken before that commit.
// A clear request returns its result, then blocks new requests while both
// tables are swept to zero.
// Reset: arst_n asynchronous; after release the same sweep runs first.
`default_nettype none

module transposition_table_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	tte_req_if.sink   req,
	tte_rsp_if.source rsp
);
	import tte_pkg::*;

	tte_cmd_t  cmd;
	tte_stat_t stat;

	tte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tte_datapath u_datapath (
		.clk      (clk),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_data (rsp.data)
	);

endmodule

`default_nettype wire

// ----- tb/tb_transposition_table_engine.sv -----
// Testbench for transposition_table_engine: directed and random requests checked by a table mirror.
`default_nettype none

module tb_transposition_table_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import tte_pkg::*;

	localparam logic [2:0] FUNC_SPARE6 = 3'd6;
	localparam logic [2:0] FUNC_SPARE7 = 3'd7;
	localparam int RAND_ITEMS  = 1950;
	localparam int POOL_SIZE   = 24;
	localparam int STALL_LIMIT = 6000;
	localparam int SETTLE      = 10;

	// Mirror of both tables; predicts one result per accepted request.
	class table_mirror;
		tte_entry_t main_tab[TABLE_ENTRIES];
		tte_entry_t pv_tab[TABLE_ENTRIES];
		tte_rsp_t   pending[$];
		int         errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (main_tab[i]) begin
				main_tab[i] = '0;
				pv_tab[i]   = '0;
			end
		endfunction

		// same key with a deeper entry keeps the old contents
		function tte_entry_t stored(tte_entry_t old, tte_req_t r);
			tte_entry_t e;
			if (old.key == r.key && r.search_depth < old.depth)
				return old;
			e.key   = r.key;
			e.move  = r.move_in;
			e.depth = r.search_depth;
			e.flag  = r.bound_kind;
			e.score = r.score_in;
			return e;
		endfunction

		function void note_request(tte_req_t r);
			tte_rsp_t           o;
			tte_entry_t         e;
			logic [IDX_W-1:0]   s;
			logic signed [23:0] val;
			logic signed [23:0] lo;
			logic signed [23:0] hi;
			o  = '0;
			s  = r.key[IDX_W-1:0];
			lo = r.window_low;
			hi = r.window_high;
			case (r.func)
				FUNC_PROBE: begin
					e   = main_tab[s];
					val = e.score;
					if (e.key == r.key && e.flag != FLAG_EMPTY && e.depth >= r.search_depth) begin
						if (e.flag == FLAG_EXACT) begin
							o.status    = STAT_EXACT;
							o.score_out = e.score;
							o.move_out  = e.move;
						end else if (e.flag == FLAG_UPPER && val <= lo) begin
							o.status    = STAT_ALPHA;
							o.score_out = lo;
						end else if (e.flag == FLAG_LOWER && val >= hi) begin
							o.status    = STAT_BETA;
							o.score_out = hi;
						end
					end
				end
				FUNC_MOVE: begin
					e = main_tab[s];
					if (e.key == r.key && e.flag != FLAG_EMPTY) begin
						o.status   = STAT_HIT;
						o.move_out = e.move;
					end
				end
				FUNC_STORE:    main_tab[s] = stored(main_tab[s], r);
				FUNC_PV_MOVE: begin
					e = pv_tab[s];
					if (e.key == r.key && e.flag == FLAG_EXACT) begin
						o.status   = STAT_HIT;
						o.move_out = e.move;
					end
				end
				FUNC_PV_STORE: pv_tab[s] = stored(pv_tab[s], r);
				FUNC_CLEAR:    wipe();
				default: ;
			endcase
			pending.push_back(o);
		endfunction

		function void check_result(tte_rsp_t got);
			tte_rsp_t want;
			if (pending.size() == 0) begin
				$error("result with no request pending: status %0d score %0d move %h",
					got.status, $signed(got.score_out), got.move_out);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.score_out !== want.score_out) begin
				$error("score_out: expected %0d, got %0d",
					$signed(want.score_out), $signed(got.score_out));
				errors++;
			end
			if (got.move_out !== want.move_out) begin
				$error("move_out: expected %h, got %h", want.move_out, got.move_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   stall_cycles;
	logic [63:0] key_pool[POOL_SIZE];
	table_mirror mirror;

	tte_req_if req ();
	tte_rsp_if rsp ();

	transposition_table_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.data  = '0;
		rsp.ready = 1'b0;
		calm      = 1'b0;
		mirror    = new();
	end

	// receiver backpressure
	always @(posedge clk) begin
		rsp.ready <= calm || ($urandom_range(99) >= 12);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				mirror.check_result(rsp.data);
			if (req.valid && req.ready)
				mirror.note_request(req.data);
			if ((rsp.valid && rsp.ready) || (req.valid && req.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

	function automatic tte_req_t mk(input logic [2:0] func, input logic [63:0] key,
		input logic [63:0] move, input int score, input int lo, input int hi,
		input int depth, input logic [1:0] kind);
		tte_req_t r;
		r.func         = func;
		r.key          = key;
		r.move_in      = move;
		r.score_in     = 24'(score);
		r.window_low   = 24'(lo);
		r.window_high  = 24'(hi);
		r.search_depth = 7'(depth);
		r.bound_kind   = kind;
		return r;
	endfunction

	function automatic logic signed [23:0] rand_score();
		case ($urandom_range(7))
			0:       return 24'sh800000;
			1:       return 24'sh7FFFFF;
			2:       return 24'(int'($urandom_range(64)) - 32);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic tte_req_t rand_req();
		tte_req_t r;
		int       pick;
		pick = $urandom_range(999);
		if (pick < 5)
			r.func = FUNC_CLEAR;
		else if (pick < 15)
			r.func = pick[0] ? FUNC_SPARE6 : FUNC_SPARE7;
		else if (pick < 320)
			r.func = FUNC_PROBE;
		else if (pick < 440)
			r.func = FUNC_MOVE;
		else if (pick < 700)
			r.func = FUNC_STORE;
		else if (pick < 820)
			r.func = FUNC_PV_MOVE;
		else
			r.func = FUNC_PV_STORE;
		if ($urandom_range(99) < 85)
			r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
		else
			r.key = {$urandom, $urandom};
		r.move_in      = {$urandom, $urandom};
		r.score_in     = rand_score();
		r.window_low   = rand_score();
		r.window_high  = rand_score();
		r.search_depth = $urandom_range(1) ? 7'($urandom_range(15)) : 7'($urandom);
		r.bound_kind   = 2'($urandom);
		return r;
	endfunction

	// present one request, with a random gap before it, and wait for acceptance
	task automatic issue(input tte_req_t r);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 12)
				gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= r;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (mirror.pending.size() != 0);
	endtask

	initial begin
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [63:0] k4;
		logic [63:0] k5;
		k1 = 64'h0123_4567_89AB_C015;
		k2 = 64'hFEDC_BA98_7654_3015;   // same slot as k1
		k3 = 64'hFFFF_FFFF_FFFF_FFFF;
		k4 = 64'h0;
		k5 = 64'h8000_0000_0000_0200;

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};
		// slot collisions: same low bits, different key
		for (int i = 16; i < 22; i++)
			key_pool[i] = {$urandom, $urandom} & ~64'(LAST_IDX) | (key_pool[i-16] & 64'(LAST_IDX));
		key_pool[22] = 64'h0;
		key_pool[23] = 64'hFFFF_FFFF_FFFF_FFFF;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tables, key zero matches the reset contents but is empty
		issue(mk(FUNC_PROBE, 64'h0, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_MOVE, 64'h0, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_PV_MOVE, 64'h0, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		// exact entry, depth gate
		issue(mk(FUNC_STORE, k1, 64'hDEAD_BEEF_0BAD_F00D, 100, 0, 0, 10, FLAG_EXACT));
		issue(mk(FUNC_PROBE, k1, 64'h0, 0, 0, 0, 10, FLAG_EMPTY));
		issue(mk(FUNC_PROBE, k1, 64'h0, 0, 0, 0, 11, FLAG_EMPTY));
		issue(mk(FUNC_MOVE, k1, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_PV_MOVE, k1, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_PV_STORE, k1, 64'hFFFF_FFFF_FFFF_FFFF, 8388607, 0, 0, 127, FLAG_EXACT));
		issue(mk(FUNC_PV_MOVE, k1, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		// shallower store on the same key is dropped
		issue(mk(FUNC_STORE, k1, 64'h1, -5, 0, 0, 5, FLAG_LOWER));
		issue(mk(FUNC_PROBE, k1, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		// different key in the same slot evicts
		issue(mk(FUNC_STORE, k2, 64'h2, -8388608, 0, 0, 0, FLAG_UPPER));
		issue(mk(FUNC_PROBE, k2, 64'h0, 0, -8388608, 8388607, 0, FLAG_EMPTY));
		issue(mk(FUNC_PROBE, k1, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_STORE, k2, 64'h3, 50, 0, 0, 3, FLAG_UPPER));
		issue(mk(FUNC_PROBE, k2, 64'h0, 0, 49, 8388607, 3, FLAG_EMPTY));
		// lower bound cut at the top of the range
		issue(mk(FUNC_STORE, k3, 64'h4, 8388607, 0, 0, 127, FLAG_LOWER));
		issue(mk(FUNC_PROBE, k3, 64'h0, 0, -8388608, 8388607, 127, FLAG_EMPTY));
		// empty-flag store never hits but guards its key
		issue(mk(FUNC_STORE, k4, 64'h5, 7, 0, 0, 20, FLAG_EMPTY));
		issue(mk(FUNC_MOVE, k4, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_STORE, k4, 64'h6, 8, 0, 0, 19, FLAG_EXACT));
		issue(mk(FUNC_PROBE, k4, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		// pv lookup needs an exact entry
		issue(mk(FUNC_PV_STORE, k5, 64'h7, 9, 0, 0, 1, FLAG_UPPER));
		issue(mk(FUNC_PV_MOVE, k5, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_SPARE6, k1, 64'hFFFF_FFFF_FFFF_FFFF, -1, -1, -1, 127, FLAG_LOWER));
		issue(mk(FUNC_SPARE7, k1, 64'hFFFF_FFFF_FFFF_FFFF, -1, -1, -1, 127, FLAG_LOWER));
		issue(mk(FUNC_CLEAR, 64'h0, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));
		issue(mk(FUNC_PV_MOVE, k1, 64'h0, 0, 0, 0, 0, FLAG_EMPTY));

		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = (i >= 700 && i < 1000);
			if (i == 400 || i == 1200)
				drain();
			issue(rand_req());
		end
		calm = 1'b0;

		// the last request is noted by the monitor at its accepting edge
		drain();
		repeat (SETTLE) @(posedge clk);

		if (mirror.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
